// ----- rtl/core/kdm_pkg.sv -----
package kdm_pkg;

  localparam int unsigned FracBitsDef = 14;

  // round(sqrt(3)/2 * 2^30)
  localparam logic [31:0] Sqrt3HalfQ30 = 32'd929887697;

  // magic multiplier for unsigned divide by three of a 16 bit value
  localparam logic [15:0] DivThreeMul = 16'd43691;
  localparam int unsigned DivThreeShift = 17;

  localparam int unsigned NumW = 64;
  localparam int unsigned DenW = 48;

  localparam logic [15:0] GainDivRst = 16'd256;
  localparam logic [14:0] HoldLimRst = 15'd4915;
  localparam logic [14:0] RotThrRst  = 15'd1638;
  localparam logic [14:0] DeadbandRst = 15'd1311;

  typedef enum logic [1:0] {
    RegGainDiv  = 2'd0,
    RegHoldLim  = 2'd1,
    RegRotThr   = 2'd2,
    RegDeadband = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OmRobot    = 2'd0,
    OmHeld     = 2'd1,
    OmReversed = 2'd2,
    OmSpare    = 2'd3
  } orient_e;

  localparam logic [2:0] HpManual    = 3'd1;
  localparam logic [2:0] HpEntering  = 3'd2;
  localparam logic [2:0] HpHolding   = 3'd3;
  localparam logic [2:0] HpCancelled = 3'd4;
  localparam logic [2:0] HpIdle      = 3'd5;

endpackage

// ----- rtl/core/kiwi_drive_mixer_heading_hold_core.sv -----
// Three-wheel kiwi drive mixer with heading hold.
// Input channel: one joystick sample per transfer (in_valid_i / in_ready_o),
// carrying x, y, rotation, sprint, orientation button, hold cancel and
// request, and the gyro heading. Output channel: one set of three wheel
// drives per input item (out_valid_o / out_ready_i).
// Config: write cfg_data_i to register cfg_index_i while cfg_we_i is high,
// only while the block is idle.
// Each item is worked by a small sequencer around one shared multiplier and
// one shared 48 bit subtractor, which does both the 16 step square root and
// the 64 step restoring divisions (one quotient bit per cycle).
// The three translation divides are skipped for a zero stick, the hold
// divide runs only while holding, and the three rescale divides run only
// when the largest wheel magnitude exceeds full scale. One item is in
// work at a time; in_ready_o is high only while the sequencer is idle.
// The finished result sits in an output register; a new input item is taken
// while that result still waits, and the sequencer stalls at its last step
// only if the previous result has not yet been taken.
// Reset (rst_ni low) clears the config registers to their defaults, puts the
// orientation machine in robot mode and the hold machine in idle.
module kiwi_drive_mixer_heading_hold_core
  import kdm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] drive_x_i,
  input  logic signed [15:0] drive_y_i,
  input  logic signed [15:0] drive_rot_i,
  input  logic               sprint_i,
  input  logic               orient_button_i,
  input  logic               hold_cancel_i,
  input  logic               hold_request_i,
  input  logic signed [15:0] gyro_heading_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] wheel_left_o,
  output logic signed [15:0] wheel_right_o,
  output logic signed [15:0] wheel_back_o
);

  localparam logic [4:0] StIdle  = 5'd0;
  localparam logic [4:0] StSqx   = 5'd1;
  localparam logic [4:0] StSqy   = 5'd2;
  localparam logic [4:0] StSqrt  = 5'd3;
  localparam logic [4:0] StKy    = 5'd4;
  localparam logic [4:0] StVec   = 5'd5;
  localparam logic [4:0] StVmax  = 5'd6;
  localparam logic [4:0] StMlo   = 5'd7;
  localparam logic [4:0] StMhi   = 5'd8;
  localparam logic [4:0] StTdone = 5'd9;
  localparam logic [4:0] StDiv   = 5'd10;
  localparam logic [4:0] StCorr  = 5'd11;
  localparam logic [4:0] StCorrd = 5'd12;
  localparam logic [4:0] StWsum  = 5'd13;
  localparam logic [4:0] StWmax  = 5'd14;
  localparam logic [4:0] StNorm  = 5'd15;
  localparam logic [4:0] StNset  = 5'd16;
  localparam logic [4:0] StNdone = 5'd17;
  localparam logic [4:0] StOut   = 5'd18;

  localparam logic [5:0] DivLast  = 6'(NumW - 1);
  localparam logic [3:0] SqrtLast = 4'd15;

  // config
  logic [15:0] gain_div_q;
  logic [14:0] hold_lim_q;
  logic [14:0] rot_thr_q;
  logic [14:0] deadband_q;

  // persistent machines
  orient_e     orient_q;
  logic        came_robot_q;
  logic [2:0]  phase_q;
  logic signed [15:0] held_q;

  // sequencer and datapath
  logic [4:0]  state_q;
  logic [4:0]  ret_q;
  logic [5:0]  cnt_q;
  logic [1:0]  wi_q;
  logic signed [16:0] x_q;
  logic signed [16:0] y_q;
  logic signed [16:0] r_q;
  logic [15:0] ax_q;
  logic [15:0] ay_q;
  logic        do_corr_q;
  logic [16:0] dmag_q;
  logic        dneg_q;
  logic [63:0] acc_q;
  logic [63:0] num_q;
  logic [47:0] rem_q;
  logic [47:0] den_q;
  logic [15:0] root_q;
  logic signed [47:0] v_q [3];
  logic [46:0] maxv_q;
  logic signed [17:0] t_q [3];
  logic signed [17:0] rtot_q;
  logic signed [18:0] w_q [3];
  logic [17:0] maxw_q;
  logic        out_valid_q;
  logic signed [15:0] out_l_q;
  logic signed [15:0] out_r_q;
  logic signed [15:0] out_b_q;

  // input conditioning
  logic signed [16:0] xs, ys, xh, yh, xo, yo;
  logic [15:0] rmag, r3, rsc;
  logic [31:0] r3_prod;
  logic signed [16:0] r_d;
  logic        above;
  logic [2:0]  ph;
  logic signed [16:0] diff;
  logic        accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    xs = 17'(drive_x_i);
    ys = 17'(drive_y_i);
    xh = sprint_i ? xs : ((xs + $signed(17'(xs[16]))) >>> 1);
    yh = sprint_i ? ys : ((ys + $signed(17'(ys[16]))) >>> 1);
    xo = (orient_q == OmReversed) ? -xh : xh;
    yo = (orient_q == OmReversed) ? -yh : yh;
    rmag = drive_rot_i[15] ? 16'(-17'(drive_rot_i)) : 16'(drive_rot_i);
    r3_prod = rmag * DivThreeMul;
    r3 = 16'(r3_prod >> DivThreeShift);
    rsc = sprint_i ? rmag : r3;
    r_d = drive_rot_i[15] ? -17'(rsc) : 17'(rsc);
    above = rsc > 16'(rot_thr_q);
    ph = hold_cancel_i ? HpCancelled : phase_q;
    diff = 17'(held_q) - 17'(gyro_heading_i);
  end

  // shared multiplier
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] prod;
  logic [46:0] vmag_sel;

  always_comb begin
    vmag_sel = v_q[wi_q][47] ? 47'(-v_q[wi_q]) : 47'(v_q[wi_q]);
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StSqx: begin
        mul_a = 32'(ax_q);
        mul_b = ax_q;
      end
      StSqy: begin
        mul_a = 32'(ay_q);
        mul_b = ay_q;
      end
      StKy: begin
        mul_a = Sqrt3HalfQ30;
        mul_b = ay_q;
      end
      StMlo: begin
        mul_a = 32'(vmag_sel[23:0]);
        mul_b = root_q;
      end
      StMhi: begin
        mul_a = 32'(vmag_sel[46:24]);
        mul_b = root_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // shared subtractor for square root and division steps
  logic [47:0] sub_a, sub_b;
  logic [48:0] trial;
  logic        fits;

  always_comb begin
    if (state_q == StSqrt) begin
      sub_a = {rem_q[45:0], num_q[63:62]};
      sub_b = {30'b0, root_q, 2'b01};
    end else begin
      sub_a = {rem_q[46:0], num_q[63]};
      sub_b = den_q;
    end
    trial = {1'b0, sub_a} - {1'b0, sub_b};
    fits = !trial[48];
  end

  // helpers
  logic signed [47:0] x29, ky;
  logic [46:0] vm0, vm1, vm2;
  logic [17:0] wm0, wm1, wm2;
  logic [14:0] corr_mag;

  always_comb begin
    x29 = 48'(x_q) <<< 29;
    ky = y_q[16] ? -48'(acc_q[45:0]) : 48'(acc_q[45:0]);
    vm0 = v_q[0][47] ? 47'(-v_q[0]) : 47'(v_q[0]);
    vm1 = v_q[1][47] ? 47'(-v_q[1]) : 47'(v_q[1]);
    vm2 = v_q[2][47] ? 47'(-v_q[2]) : 47'(v_q[2]);
    wm0 = w_q[0][18] ? 18'(-w_q[0]) : 18'(w_q[0]);
    wm1 = w_q[1][18] ? 18'(-w_q[1]) : 18'(w_q[1]);
    wm2 = w_q[2][18] ? 18'(-w_q[2]) : 18'(w_q[2]);
    corr_mag = (num_q > 64'(hold_lim_q)) ? hold_lim_q : num_q[14:0];
  end

  logic [46:0] maxv_d;
  logic [17:0] maxw_d;
  logic [17:0] wsel_mag;

  always_comb begin
    maxv_d = vm0;
    if (vm1 > maxv_d) begin
      maxv_d = vm1;
    end
    if (vm2 > maxv_d) begin
      maxv_d = vm2;
    end
    maxw_d = wm0;
    if (wm1 > maxw_d) begin
      maxw_d = wm1;
    end
    if (wm2 > maxw_d) begin
      maxw_d = wm2;
    end
    wsel_mag = w_q[wi_q][18] ? 18'(-w_q[wi_q]) : 18'(w_q[wi_q]);
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_div_q   <= GainDivRst;
      hold_lim_q   <= HoldLimRst;
      rot_thr_q    <= RotThrRst;
      deadband_q   <= DeadbandRst;
      orient_q     <= OmRobot;
      came_robot_q <= 1'b1;
      phase_q      <= HpIdle;
      held_q       <= '0;
      state_q      <= StIdle;
      ret_q        <= StIdle;
      cnt_q        <= '0;
      wi_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          RegGainDiv:  gain_div_q <= cfg_data_i;
          RegHoldLim:  hold_lim_q <= cfg_data_i[14:0];
          RegRotThr:   rot_thr_q <= cfg_data_i[14:0];
          RegDeadband: deadband_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i && state_q != StOut) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (accept) begin
            unique case (orient_q)
              OmHeld: begin
                if (!orient_button_i) begin
                  orient_q <= came_robot_q ? OmReversed : OmRobot;
                end
              end
              OmReversed: begin
                came_robot_q <= 1'b0;
                if (orient_button_i) begin
                  orient_q <= OmHeld;
                end
              end
              default: begin
                came_robot_q <= 1'b1;
                if (orient_button_i) begin
                  orient_q <= OmHeld;
                end
              end
            endcase

            do_corr_q <= (ph == HpHolding);
            unique case (ph)
              HpManual: begin
                phase_q <= above ? HpManual : HpEntering;
              end
              HpEntering: begin
                held_q  <= gyro_heading_i;
                phase_q <= above ? HpManual : HpHolding;
              end
              HpHolding: begin
                phase_q <= above ? HpManual : HpHolding;
              end
              HpCancelled: begin
                phase_q <= hold_cancel_i ? HpCancelled : HpIdle;
              end
              HpIdle: begin
                phase_q <= hold_request_i ? HpEntering : HpIdle;
              end
              default: begin
                phase_q <= HpIdle;
              end
            endcase

            x_q    <= xo;
            y_q    <= yo;
            r_q    <= r_d;
            ax_q   <= xo[16] ? 16'(-xo) : xo[15:0];
            ay_q   <= yo[16] ? 16'(-yo) : yo[15:0];
            dmag_q <= diff[16] ? 17'(-diff) : 17'(diff);
            dneg_q <= diff[16];
            state_q <= StSqx;
          end
        end

        StSqx: begin
          acc_q   <= 64'(prod);
          state_q <= StSqy;
        end

        StSqy: begin
          num_q   <= {acc_q[31:0] + prod[31:0], 32'b0};
          rem_q   <= '0;
          root_q  <= '0;
          cnt_q   <= '0;
          state_q <= StSqrt;
        end

        StSqrt: begin
          if (fits) begin
            rem_q  <= trial[47:0];
            root_q <= {root_q[14:0], 1'b1};
          end else begin
            rem_q  <= sub_a;
            root_q <= {root_q[14:0], 1'b0};
          end
          num_q <= {num_q[61:0], 2'b00};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q[3:0] == SqrtLast) begin
            state_q <= StKy;
          end
        end

        StKy: begin
          acc_q   <= 64'(prod);
          state_q <= StVec;
        end

        StVec: begin
          v_q[0]  <= x29 + ky;
          v_q[1]  <= x29 - ky;
          v_q[2]  <= -(48'(x_q) <<< 30);
          state_q <= StVmax;
        end

        StVmax: begin
          maxv_q <= maxv_d;
          wi_q   <= '0;
          if (ax_q == '0 && ay_q == '0) begin
            t_q[0]  <= '0;
            t_q[1]  <= '0;
            t_q[2]  <= '0;
            state_q <= StCorr;
          end else begin
            state_q <= StMlo;
          end
        end

        StMlo: begin
          acc_q   <= 64'(prod);
          state_q <= StMhi;
        end

        StMhi: begin
          num_q   <= acc_q + (64'(prod) << 24);
          den_q   <= 48'(maxv_q);
          rem_q   <= '0;
          cnt_q   <= '0;
          ret_q   <= StTdone;
          state_q <= StDiv;
        end

        StDiv: begin
          // restoring divide, quotient bits shift into num_q
          rem_q <= fits ? trial[47:0] : sub_a;
          num_q <= {num_q[62:0], fits};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == DivLast) begin
            state_q <= ret_q;
          end
        end

        StTdone: begin
          t_q[wi_q] <= v_q[wi_q][47] ? -18'(num_q[16:0]) : 18'(num_q[16:0]);
          if (wi_q == 2'd2) begin
            state_q <= StCorr;
          end else begin
            wi_q    <= wi_q + 2'd1;
            state_q <= StMlo;
          end
        end

        StCorr: begin
          if (do_corr_q) begin
            num_q   <= 64'(dmag_q) << FracBitsDef;
            den_q   <= (gain_div_q == '0) ? 48'd1 : 48'(gain_div_q);
            rem_q   <= '0;
            cnt_q   <= '0;
            ret_q   <= StCorrd;
            state_q <= StDiv;
          end else begin
            rtot_q  <= 18'(r_q);
            state_q <= StWsum;
          end
        end

        StCorrd: begin
          rtot_q  <= dneg_q ? 18'(r_q) - 18'(corr_mag) : 18'(r_q) + 18'(corr_mag);
          state_q <= StWsum;
        end

        StWsum: begin
          w_q[0]  <= 19'(t_q[0]) + 19'(rtot_q);
          w_q[1]  <= 19'(t_q[1]) + 19'(rtot_q);
          w_q[2]  <= 19'(t_q[2]) + 19'(rtot_q);
          state_q <= StWmax;
        end

        StWmax: begin
          maxw_q  <= maxw_d;
          state_q <= StNorm;
        end

        StNorm: begin
          wi_q <= '0;
          priority if (maxw_q < 18'(deadband_q)) begin
            w_q[0]  <= '0;
            w_q[1]  <= '0;
            w_q[2]  <= '0;
            state_q <= StOut;
          end else if (32'(maxw_q) > (32'd1 << FracBitsDef)) begin
            state_q <= StNset;
          end else begin
            state_q <= StOut;
          end
        end

        StNset: begin
          num_q   <= 64'(wsel_mag) << FracBitsDef;
          den_q   <= 48'(maxw_q);
          rem_q   <= '0;
          cnt_q   <= '0;
          ret_q   <= StNdone;
          state_q <= StDiv;
        end

        StNdone: begin
          w_q[wi_q] <= w_q[wi_q][18] ? -19'(num_q[17:0]) : 19'(num_q[17:0]);
          if (wi_q == 2'd2) begin
            state_q <= StOut;
          end else begin
            wi_q    <= wi_q + 2'd1;
            state_q <= StNset;
          end
        end

        StOut: begin
          // wait until the previous result has been transferred
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end

        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StOut && (!out_valid_q || out_ready_i)) begin
      out_l_q <= w_q[0][15:0];
      out_r_q <= w_q[1][15:0];
      out_b_q <= w_q[2][15:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign wheel_left_o  = out_l_q;
  assign wheel_right_o = out_r_q;
  assign wheel_back_o  = out_b_q;

endmodule
